/* design/rpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_pkg : shared types and constants for the rotary pair rotation block
// Field widths, command and register codes, request and result records.
// ----------------------------------------------------------------------------
package rpr_pkg;

    localparam int MAX_HEAD_PAIRS = 128;

    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 10;
    localparam int PAIR_W     = 7;
    localparam int ROT_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_ROTATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROTARY_PAIRS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_BASE = 1'b1;

    localparam logic [ROT_W-1:0] ROTARY_PAIRS_RESET  = 7'd32;
    localparam logic [POS_W-1:0] POSITION_BASE_RESET = 10'd0;

    typedef logic [1:0] t_op;
    localparam t_op OP_WRITE = 2'd0;
    localparam t_op OP_PASS  = 2'd1;
    localparam t_op OP_ERR   = 2'd2;
    localparam t_op OP_ROT   = 2'd3;

    typedef struct packed {
        logic [ROT_W-1:0] rotary_pairs;
        logic [POS_W-1:0] position_base;
    } t_cfg;

    typedef struct packed {
        t_op                        op;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
    } t_req;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic                       passed;
        logic                       error;
    } t_res;

endpackage

/* design/rpr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_fifo : small register queue
// First-in first-out store of DEPTH entries with fill count.
// ----------------------------------------------------------------------------
module rpr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_do_push, w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* design/rpr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_front : request classifier and configuration registers
// Sorts each request into table write, copy, position error or rotation
// and forms its table address.
// ----------------------------------------------------------------------------
module rpr_front import rpr_pkg::*; #(
    parameter int MAX_POSITIONS    = 1024,
    parameter int MAX_ROTARY_PAIRS = 64
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]                             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                            i_cfg_data,
    input  logic                                             i_cmd,
    input  logic [POS_W-1:0]                                 i_position,
    input  logic [PAIR_W-1:0]                                i_pair_index,
    input  logic signed [SAMPLE_W-1:0]                       i_pair_x,
    input  logic signed [SAMPLE_W-1:0]                       i_pair_y,
    output t_req                                             o_req,
    output logic [$clog2(MAX_POSITIONS*MAX_ROTARY_PAIRS)-1:0] o_addr,
    output logic                                             o_keep
);

    localparam int AW = $clog2(MAX_POSITIONS*MAX_ROTARY_PAIRS);

    t_cfg           r_cfg;
    logic [POS_W:0] w_pos_eff;
    logic [POS_W:0] w_row;
    logic           w_pair_out;
    logic           w_pos_bad;
    logic           w_wr_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotary_pairs  <= ROTARY_PAIRS_RESET;
            r_cfg.position_base <= POSITION_BASE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROTARY_PAIRS:  r_cfg.rotary_pairs  <= i_cfg_data[ROT_W-1:0];
                CFG_POSITION_BASE: r_cfg.position_base <= i_cfg_data[POS_W-1:0];
            endcase
        end
    end

    assign w_pos_eff  = {1'b0, r_cfg.position_base} + {1'b0, i_position};
    assign w_pair_out = (i_pair_index >= r_cfg.rotary_pairs)
                     || (32'(i_pair_index) >= MAX_ROTARY_PAIRS)
                     || (32'(i_pair_index) >= MAX_HEAD_PAIRS);
    assign w_pos_bad  = (32'(w_pos_eff) >= MAX_POSITIONS);
    assign w_wr_ok    = (32'(i_position) < MAX_POSITIONS)
                     && (32'(i_pair_index) < MAX_ROTARY_PAIRS);
    assign w_row      = (i_cmd == CMD_ROTATE) ? w_pos_eff : {1'b0, i_position};

    assign o_addr = AW'(w_row) * AW'(MAX_ROTARY_PAIRS) + AW'(i_pair_index);

    always_comb begin
        o_req.x = i_pair_x;
        o_req.y = i_pair_y;
        o_keep  = 1'b1;
        if (i_cmd == CMD_WRITE) begin
            o_req.op = OP_WRITE;
            o_keep   = w_wr_ok;
        end else if (w_pair_out) begin
            o_req.op = OP_PASS;
        end else if (w_pos_bad) begin
            o_req.op = OP_ERR;
        end else begin
            o_req.op = OP_ROT;
        end
    end

endmodule

/* design/rpr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_back : table access and rotation datapath
// Table memory access, four-product multiply stage, then sum, rounding and
// saturation into the result queue.
// ----------------------------------------------------------------------------
module rpr_back import rpr_pkg::*; #(
    parameter int MAX_POSITIONS    = 1024,
    parameter int MAX_ROTARY_PAIRS = 64,
    parameter int OUT_DEPTH        = 4
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_q_valid,
    input  t_req                                             i_q_req,
    input  logic [$clog2(MAX_POSITIONS*MAX_ROTARY_PAIRS)-1:0] i_q_addr,
    output logic                                             o_q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]                   i_out_count,
    output logic                                             o_res_valid,
    output t_res                                             o_res
);

    localparam int DEPTH = MAX_POSITIONS*MAX_ROTARY_PAIRS;
    localparam int CW    = $clog2(OUT_DEPTH+1);

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [32:0] acc
    );
        logic signed [33:0] biased;
        logic signed [18:0] q;
        biased = 34'(acc) + 34'sd16384;
        q      = 19'(biased >>> 15);
        if (q > 19'sd32767) begin
            round_sat = 16'sh7FFF;
        end else if (q < -19'sd32768) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = q[SAMPLE_W-1:0];
        end
    endfunction

    logic [2*SAMPLE_W-1:0]      r_mem [DEPTH];
    logic [2*SAMPLE_W-1:0]      r_rd;
    logic                       r_s1_valid;
    t_req                       r_s1_req;
    logic                       r_s2_valid;
    t_req                       r_s2_req;
    logic signed [31:0]         r_xc, r_ys, r_yc, r_xs;
    logic [CW:0]                w_load;
    logic signed [SAMPLE_W-1:0] w_sin, w_cos;
    logic signed [32:0]         w_acc_x, w_acc_y;

    assign w_load  = (CW+1)'(i_out_count) + (CW+1)'(r_s1_valid) + (CW+1)'(r_s2_valid);
    assign o_q_pop = i_q_valid && (w_load < (CW+1)'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_q_req.op == OP_WRITE)) begin
            r_mem[i_q_addr] <= {i_q_req.x, i_q_req.y};
        end
        r_rd <= r_mem[i_q_addr];
    end

    assign w_sin = r_rd[2*SAMPLE_W-1:SAMPLE_W];
    assign w_cos = r_rd[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_q_pop && (i_q_req.op != OP_WRITE);
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_req <= i_q_req;
        r_s2_req <= r_s1_req;
        r_xc     <= r_s1_req.x * w_cos;
        r_ys     <= r_s1_req.y * w_sin;
        r_yc     <= r_s1_req.y * w_cos;
        r_xs     <= r_s1_req.x * w_sin;
    end

    assign w_acc_x = 33'(r_xc) - 33'(r_ys);
    assign w_acc_y = 33'(r_yc) + 33'(r_xs);

    assign o_res_valid = r_s2_valid;

    always_comb begin
        case (r_s2_req.op)
            OP_PASS: begin
                o_res.x      = r_s2_req.x;
                o_res.y      = r_s2_req.y;
                o_res.passed = 1'b1;
                o_res.error  = 1'b0;
            end
            OP_ERR: begin
                o_res.x      = '0;
                o_res.y      = '0;
                o_res.passed = 1'b0;
                o_res.error  = 1'b1;
            end
            default: begin
                o_res.x      = round_sat(w_acc_x);
                o_res.y      = round_sat(w_acc_y);
                o_res.passed = 1'b0;
                o_res.error  = 1'b0;
            end
        endcase
    end

endmodule

/* design/rotary_pair_rotation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_pair_rotation : interleaved rotary position embedding
// Rotates (x, y) element pairs by a per-position, per-pair sine/cosine table.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue port: drive the fields and raise push; a
//   request is taken at a clock edge with push high and full low. A request
//   with i_cmd low loads the sine (i_pair_x) and cosine (i_pair_y) entry at
//   row i_position, column i_pair_index, and gives no result. A request with
//   i_cmd high gives one result: the rotated pair, a copy or a position error.
//   Results leave through a queue port: while empty is low the oldest result
//   is on the o_ ports; it is taken at an edge with pop high.
//   A rotation passes the request queue, the table read and product registers
//   and the result queue. Throughput: one request per cycle while the result
//   queue has room, set by the single table port, one access per request.
//   Configuration writes (index 0 rotary pairs, 1 position base) are taken
//   at once; issue them only while no request is in flight.
//   Reset empties both queues and the pipeline; the table is not cleared.
//   When pop stays low, results collect in a four-deep queue and the
//   datapath, then the request queue fills and full rises.
// ----------------------------------------------------------------------------
module rotary_pair_rotation import rpr_pkg::*; #(
    parameter int MAX_POSITIONS    = 1024,
    parameter int MAX_ROTARY_PAIRS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_cmd,
    input  logic [POS_W-1:0]           i_position,
    input  logic [PAIR_W-1:0]          i_pair_index,
    input  logic signed [SAMPLE_W-1:0] i_pair_x,
    input  logic signed [SAMPLE_W-1:0] i_pair_y,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] o_out_x,
    output logic signed [SAMPLE_W-1:0] o_out_y,
    output logic                       o_passed_through,
    output logic                       o_position_error
);

    localparam int AW        = $clog2(MAX_POSITIONS*MAX_ROTARY_PAIRS);
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int CMD_W     = AW + $bits(t_req);
    localparam int RES_W     = $bits(t_res);

    t_req                            w_front_req;
    logic [AW-1:0]                   w_front_addr;
    logic                            w_front_keep;
    logic [CMD_W-1:0]                w_q_data;
    logic                            w_q_empty;
    logic                            w_q_pop;
    logic [$clog2(OUT_DEPTH+1)-1:0]  w_out_count;
    logic                            w_res_valid;
    t_res                            w_res;
    t_res                            w_out;

    assign o_cfg_ready = 1'b1;

    rpr_front #(
        .MAX_POSITIONS    (MAX_POSITIONS),
        .MAX_ROTARY_PAIRS (MAX_ROTARY_PAIRS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_pair_index (i_pair_index),
        .i_pair_x     (i_pair_x),
        .i_pair_y     (i_pair_y),
        .o_req        (w_front_req),
        .o_addr       (w_front_addr),
        .o_keep       (w_front_keep)
    );

    rpr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full && w_front_keep),
        .i_data  ({w_front_addr, w_front_req}),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty),
        .o_count ()
    );

    rpr_back #(
        .MAX_POSITIONS    (MAX_POSITIONS),
        .MAX_ROTARY_PAIRS (MAX_ROTARY_PAIRS),
        .OUT_DEPTH        (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!w_q_empty),
        .i_q_req     (w_q_data[$bits(t_req)-1:0]),
        .i_q_addr    (w_q_data[CMD_W-1:$bits(t_req)]),
        .o_q_pop     (w_q_pop),
        .i_out_count (w_out_count),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    rpr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (w_out),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_out_x          = w_out.x;
    assign o_out_y          = w_out.y;
    assign o_passed_through = w_out.passed;
    assign o_position_error = w_out.error;

endmodule

/* design/rpr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_checker : port-level checks for rotary_pair_rotation
// Watches the queue ports and result flags over time.
// ----------------------------------------------------------------------------
module rpr_checker import rpr_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic signed [SAMPLE_W-1:0] o_out_x,
    input logic signed [SAMPLE_W-1:0] o_out_y,
    input logic                       o_passed_through,
    input logic                       o_position_error
);

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_passed_through) |-> !o_position_error)
        else $error("copied result flagged as position error");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_position_error) |-> (o_out_x == '0 && o_out_y == '0))
        else $error("position error result not zero");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_x) && $stable(o_out_y)
                              && $stable(o_passed_through)
                              && $stable(o_position_error)))
        else $error("waiting result changed");

endmodule

bind rotary_pair_rotation rpr_checker u_rpr_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for rotary_pair_rotation
// Loads sine/cosine entries and rotates pairs under several rotary widths and
// position bases, comparing every result with an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module testbench;
    import rpr_pkg::*;

    localparam int MAX_POSITIONS    = 1024;
    localparam int MAX_ROTARY_PAIRS = 64;
    localparam int TABLE_ENTRIES    = MAX_POSITIONS * MAX_ROTARY_PAIRS;
    localparam int SETTLE_CYCLES    = 16;
    localparam int RX_HOLDOFF       = 200;
    localparam int ITEMS_PER_PHASE  = 290;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int REPORT_LIMIT     = 10;

    class pair_rotation_scoreboard;
        logic signed [SAMPLE_W-1:0] sine_tab [0:TABLE_ENTRIES-1];
        logic signed [SAMPLE_W-1:0] cosine_tab [0:TABLE_ENTRIES-1];
        int unsigned                rotary_pairs;
        int unsigned                position_base;
        t_res                       expected_pairs [$];
        int                         mismatches;
        int                         results_seen;

        function new();
            rotary_pairs  = ROTARY_PAIRS_RESET;
            position_base = POSITION_BASE_RESET;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ROTARY_PAIRS) begin
                rotary_pairs = data[ROT_W-1:0];
            end else begin
                position_base = data[POS_W-1:0];
            end
        endfunction

        function int unsigned rotary_width();
            return (rotary_pairs > MAX_ROTARY_PAIRS) ? MAX_ROTARY_PAIRS : rotary_pairs;
        endfunction

        function logic signed [SAMPLE_W-1:0] round_sat(longint acc);
            longint r;
            r = (acc + 64'sd16384) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[SAMPLE_W-1:0];
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        function void note_request(logic cmd, logic [POS_W-1:0] pos, logic [PAIR_W-1:0] pair,
                                   logic signed [SAMPLE_W-1:0] x,
                                   logic signed [SAMPLE_W-1:0] y);
            int unsigned row;
            int unsigned addr;
            longint      s;
            longint      c;
            t_res        r;
            if (cmd == CMD_WRITE) begin
                if (pair < MAX_ROTARY_PAIRS) begin
                    addr = pos * MAX_ROTARY_PAIRS + pair;
                    sine_tab[addr]   = x;
                    cosine_tab[addr] = y;
                end
                return;
            end
            row = position_base + pos;
            if (pair >= rotary_width()) begin
                r = '{x: x, y: y, passed: 1'b1, error: 1'b0};
            end else if (row >= MAX_POSITIONS) begin
                r = '{x: '0, y: '0, passed: 1'b0, error: 1'b1};
            end else begin
                addr = row * MAX_ROTARY_PAIRS + pair;
                s = longint'(sine_tab[addr]);
                c = longint'(cosine_tab[addr]);
                r.x = round_sat(longint'(x) * c - longint'(y) * s);
                r.y = round_sat(longint'(y) * c + longint'(x) * s);
                r.passed = 1'b0;
                r.error  = 1'b0;
            end
            expected_pairs.push_back(r);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
        endfunction

        function void check_result(t_res got);
            t_res want;
            results_seen++;
            if (expected_pairs.size() == 0) begin
                report($sformatf("result %0d with no request pending: x=%0d y=%0d pass=%0b err=%0b",
                                 results_seen, got.x, got.y, got.passed, got.error));
                return;
            end
            want = expected_pairs.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.passed !== want.passed ||
                got.error !== want.error) begin
                report($sformatf({"result %0d mismatch: expected x=%0d y=%0d pass=%0b err=%0b,",
                                  " got x=%0d y=%0d pass=%0b err=%0b"},
                                 results_seen, want.x, want.y, want.passed, want.error,
                                 got.x, got.y, got.passed, got.error));
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;
    logic                       push;
    logic                       full;
    logic                       i_cmd;
    logic [POS_W-1:0]           i_position;
    logic [PAIR_W-1:0]          i_pair_index;
    logic signed [SAMPLE_W-1:0] i_pair_x;
    logic signed [SAMPLE_W-1:0] i_pair_y;
    logic                       empty;
    logic                       pop;
    logic signed [SAMPLE_W-1:0] o_out_x;
    logic signed [SAMPLE_W-1:0] o_out_y;
    logic                       o_passed_through;
    logic                       o_position_error;

    pair_rotation_scoreboard rot_sb = new();

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          rx_holdoff_req = 1'b0;
    int unsigned cycle_count = 0;
    bit          written_map [0:TABLE_ENTRIES-1];
    int unsigned written_addrs [$];

    rotary_pair_rotation #(
        .MAX_POSITIONS   (MAX_POSITIONS),
        .MAX_ROTARY_PAIRS(MAX_ROTARY_PAIRS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_position      (i_position),
        .i_pair_index    (i_pair_index),
        .i_pair_x        (i_pair_x),
        .i_pair_y        (i_pair_y),
        .empty           (empty),
        .pop             (pop),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_passed_through(o_passed_through),
        .o_position_error(o_position_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            rot_sb.check_result('{x: o_out_x, y: o_out_y, passed: o_passed_through,
                                  error: o_position_error});
        end
    end

    // Result side: random pop, with a long hold-off on request.
    initial begin
        int unsigned holdoff_left;
        pop = 1'b0;
        holdoff_left = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left == 0 && rx_holdoff_req) begin
                rx_holdoff_req = 1'b0;
                holdoff_left = RX_HOLDOFF;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(15))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_request(logic cmd, logic [POS_W-1:0] pos, logic [PAIR_W-1:0] pair,
                                logic signed [SAMPLE_W-1:0] x,
                                logic signed [SAMPLE_W-1:0] y);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_cmd        <= cmd;
        i_position   <= pos;
        i_pair_index <= pair;
        i_pair_x     <= x;
        i_pair_y     <= y;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        rot_sb.note_request(cmd, pos, pair, x, y);
    endtask

    task automatic send_table_write(int unsigned row, int unsigned pair,
                                    logic signed [SAMPLE_W-1:0] s,
                                    logic signed [SAMPLE_W-1:0] c);
        int unsigned addr;
        push_request(CMD_WRITE, POS_W'(row), PAIR_W'(pair), s, c);
        if (pair < MAX_ROTARY_PAIRS) begin
            addr = row * MAX_ROTARY_PAIRS + pair;
            if (!written_map[addr]) begin
                written_map[addr] = 1'b1;
                written_addrs.push_back(addr);
            end
        end
    endtask

    task automatic send_rotate(int unsigned pos, int unsigned pair,
                               logic signed [SAMPLE_W-1:0] x,
                               logic signed [SAMPLE_W-1:0] y);
        push_request(CMD_ROTATE, POS_W'(pos), PAIR_W'(pair), x, y);
    endtask

    task automatic write_config(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        rot_sb.set_register(idx, CFG_DATA_W'(data));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop push, wait for every result, then let the pipeline settle.
    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (rot_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random(inout int count);
        int unsigned w;
        int unsigned base;
        int unsigned kind;
        int unsigned row;
        int unsigned pair;
        int unsigned addr;
        bit          found;
        w    = rot_sb.rotary_width();
        base = rot_sb.position_base;
        kind = $urandom_range(99);
        if (kind < 15) begin
            pair = $urandom_range(MAX_HEAD_PAIRS - 1);
            send_table_write($urandom_range(MAX_POSITIONS - 1), pair, rand_sample(),
                             rand_sample());
            count++;
        end else if (kind < 25 || w == 0 || (kind < 35 && base == 0)) begin
            send_rotate($urandom_range(MAX_POSITIONS - 1),
                        $urandom_range(MAX_HEAD_PAIRS - 1, w), rand_sample(), rand_sample());
            count++;
        end else if (kind < 35) begin
            send_rotate($urandom_range(MAX_POSITIONS - 1, MAX_POSITIONS - base),
                        $urandom_range(w - 1), rand_sample(), rand_sample());
            count++;
        end else begin
            found = 1'b0;
            for (int t = 0; t < 8 && !found && written_addrs.size() > 0; t++) begin
                addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
                row  = addr / MAX_ROTARY_PAIRS;
                pair = addr % MAX_ROTARY_PAIRS;
                found = (row >= base) && (pair < w);
            end
            if (!found) begin
                row  = $urandom_range(MAX_POSITIONS - 1, base);
                pair = $urandom_range(w - 1);
                if (!written_map[row * MAX_ROTARY_PAIRS + pair]) begin
                    send_table_write(row, pair, rand_sample(), rand_sample());
                    count++;
                end
            end
            send_rotate(row - base, pair, rand_sample(), rand_sample());
            count++;
        end
    endtask

    initial begin
        int count;
        int seg_rotary [6];
        int seg_base [6];
        seg_rotary   = '{64, 0, 127, 1, 64, 0};
        seg_base     = '{0, 1023, 1000, 512, 300, 0};
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_cmd        = CMD_WRITE;
        i_position   = '0;
        i_pair_index = '0;
        i_pair_x     = '0;
        i_pair_y     = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_ROTARY_PAIRS;
        i_cfg_data   = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first at the reset settings, then with position base 1.
        send_table_write(0, 0, 16'sd0, 16'sd32767);
        send_rotate(0, 0, 16'sd32767, -16'sd32768);
        send_table_write(1023, 31, -16'sd32768, -16'sd32768);
        send_rotate(1023, 31, -16'sd32768, -16'sd32768);
        send_table_write(5, 3, 16'sd32767, 16'sd32767);
        send_rotate(5, 3, 16'sd32767, -16'sd32768);
        send_table_write(6, 4, 16'sd0, 16'sd16384);
        send_rotate(6, 4, 16'sd1, -16'sd1);
        send_rotate(6, 4, 16'sd3, -16'sd3);
        send_table_write(7, 64, 16'sd100, 16'sd200);
        send_table_write(8, 127, -16'sd1, -16'sd1);
        send_rotate(7, 64, -16'sd32768, 16'sd32767);
        send_rotate(8, 127, 16'sd32767, -16'sd32768);
        send_rotate(9, 32, 16'sd12345, -16'sd12345);
        send_rotate(0, 0, 16'sd0, 16'sd0);
        wait_idle();
        write_config(CFG_POSITION_BASE, 1);
        send_rotate(1023, 0, 16'sd1, 16'sd1);
        send_rotate(1023, 40, 16'sd5, 16'sd6);
        send_rotate(1022, 31, 16'sd1000, -16'sd1000);
        send_table_write(10, 2, 16'sd23170, 16'sd23170);
        send_rotate(9, 2, 16'sd32767, 16'sd32767);
        wait_idle();

        seg_rotary[5] = $urandom_range(127);
        seg_base[5]   = $urandom_range(MAX_POSITIONS - 1);
        for (int seg = 0; seg < 6; seg++) begin
            write_config(CFG_ROTARY_PAIRS, seg_rotary[seg]);
            write_config(CFG_POSITION_BASE, seg_base[seg]);
            if (seg < 2) begin
                tx_idle_pct = 7;
                rx_idle_pct = 64;
            end else if (seg < 4) begin
                tx_idle_pct = 64;
                rx_idle_pct = 7;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (seg == 4) rx_holdoff_req = 1'b1;
            count = 0;
            while (count < ITEMS_PER_PHASE) send_random(count);
            wait_idle();
        end

        if (rot_sb.mismatches == 0 && rot_sb.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

/* sim.f */
design/rpr_pkg.sv
design/rpr_fifo.sv
design/rpr_front.sv
design/rpr_back.sv
design/rotary_pair_rotation.sv
design/rpr_checker.sv
tb/testbench.sv
